FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define PMO_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet while reset is asserted
`define PMO_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/pmo_pkg.sv
`default_nettype none
package pmo_pkg;

    localparam int FRAC_BITS = 12;

    // 0.1 square units in Q.24
    localparam logic [20:0] DEN_FLOOR = 21'd1677722;
    localparam logic [40:0] QUOT_CAP  = 41'h100_0000_0000;

    localparam logic [6:0] SQRT_STEPS = 7'd31;
    localparam logic [6:0] DIV_STEPS  = 7'd90;

    localparam logic OP_SQRT = 1'b0;
    localparam logic OP_DIV  = 1'b1;

    typedef struct packed {
        logic start;
        logic op;
    } iter_ctl_t;

    typedef struct packed {
        logic        done;
        logic [40:0] value;
    } iter_sts_t;

    function automatic logic [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -44'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/polyline_miter_offset.sv
`default_nettype none
// Miter offset of a street centre polyline. Vertices come in one transaction at a
// time (Q19.12 x, z, height and a last flag); each result carries the miter point
// offset by the configured width, its mirror through the middle vertex and the
// middle height. The first vertex of a line gives no result; every later vertex
// gives one result, the last vertex two. The work on a result is done by one
// shared iterative unit that does two 31-step square roots and two 90-step
// divisions per result, plus 15 passes through one registered 32x32 multiplier.
// The input is not ready while a vertex is in work; a finished result waits in
// the output register without holding up the next input transaction. The user
// must write offset_width only while the block is idle; the block does not enforce it.
module polyline_miter_offset (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [15:0]        cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_point_x,
    input  wire logic signed [31:0] s_point_z,
    input  wire logic signed [31:0] s_point_height,
    input  wire logic               s_last_point,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_near_x,
    output logic signed [31:0]      m_near_z,
    output logic signed [31:0]      m_far_x,
    output logic signed [31:0]      m_far_z,
    output logic signed [31:0]      m_out_height,
    output logic                    m_end_of_line
);
    import pmo_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIFF   = 3'd1;
    localparam logic [2:0] ST_SHRINK = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_ACC    = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    // multiplier program
    localparam logic [3:0] K_UXX   = 4'd0;
    localparam logic [3:0] K_UZZ   = 4'd1;
    localparam logic [3:0] K_WXX   = 4'd2;
    localparam logic [3:0] K_WZZ   = 4'd3;
    localparam logic [3:0] K_CA    = 4'd4;
    localparam logic [3:0] K_UWX   = 4'd5;
    localparam logic [3:0] K_UWZ   = 4'd6;
    localparam logic [3:0] K_CUZ   = 4'd7;
    localparam logic [3:0] K_AWZ   = 4'd8;
    localparam logic [3:0] K_AWX   = 4'd9;
    localparam logic [3:0] K_CUX   = 4'd10;
    localparam logic [3:0] K_NLO_X = 4'd11;
    localparam logic [3:0] K_NHI_X = 4'd12;
    localparam logic [3:0] K_NLO_Z = 4'd13;
    localparam logic [3:0] K_NHI_Z = 4'd14;

    logic [2:0]  state_reg;
    logic [15:0] ow_reg;

    logic signed [31:0] older_x_reg, older_z_reg;
    logic signed [31:0] newer_x_reg, newer_z_reg, newer_h_reg;
    logic [1:0]         pts_reg;

    logic signed [31:0] in_x_reg, in_z_reg, in_h_reg;
    logic               in_last_reg;
    logic               phase_reg;

    logic signed [31:0] mid_x_reg, mid_z_reg, hgt_reg;
    logic               eol_reg;
    logic signed [32:0] dux_reg, duz_reg, dwx_reg, dwz_reg;
    logic signed [31:0] ux_reg, uz_reg, wx_reg, wz_reg;
    logic               flat_reg;
    logic [1:0]         sh_reg;

    logic [3:0]         step_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic [30:0]        a_reg, c_reg;
    logic [61:0]        d_reg;
    logic signed [63:0] nx_reg, nz_reg;
    logic [58:0]        p0_reg;
    logic signed [41:0] offx_reg, offz_reg;

    logic               m_valid_reg;
    logic signed [31:0] near_x_reg, near_z_reg, far_x_reg, far_z_reg, height_reg;
    logic               eol_out_reg;

    iter_ctl_t   it_ctl;
    iter_sts_t   it_sts;
    logic [61:0] it_rad;
    logic [89:0] it_dvd;

    logic               s_fire;
    logic               tailish;
    logic signed [32:0] u_x, u_z, w_x, w_z;
    logic [32:0]        mag_ux, mag_uz, mag_wx, mag_wz;
    logic [1:0]         shift;
    logic signed [31:0] opa, opb;
    logic [63:0]        nmag;
    logic signed [63:0] acc_add, acc_sub;
    logic [58:0]        p_hi;
    logic signed [41:0] q_pos;
    logic signed [43:0] mx44, mz44, wr44, near_x_full, near_z_full, far_x_full, far_z_full;
    logic [31:0]        near_x_sat, near_z_sat;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

    function automatic logic signed [31:0] shrink(input logic signed [32:0] v,
                                                  input logic [1:0] s);
        logic [32:0] m;
        logic [32:0] r;
        m = mag33(v) >> s;
        r = v[32] ? 33'(-m) : m;
        return r[31:0];
    endfunction

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // window operands
    always_comb begin
        tailish = phase_reg || (pts_reg == 2'd1);
        if (tailish) begin
            u_x = {newer_x_reg[31], newer_x_reg} - {in_x_reg[31], in_x_reg};
            u_z = {newer_z_reg[31], newer_z_reg} - {in_z_reg[31], in_z_reg};
        end else begin
            u_x = {older_x_reg[31], older_x_reg} - {newer_x_reg[31], newer_x_reg};
            u_z = {older_z_reg[31], older_z_reg} - {newer_z_reg[31], newer_z_reg};
        end
        w_x = {in_x_reg[31], in_x_reg} - {newer_x_reg[31], newer_x_reg};
        w_z = {in_z_reg[31], in_z_reg} - {newer_z_reg[31], newer_z_reg};
    end

    // common right shift that keeps every edge component below 2^30
    always_comb begin
        mag_ux = mag33(dux_reg);
        mag_uz = mag33(duz_reg);
        mag_wx = mag33(dwx_reg);
        mag_wz = mag33(dwz_reg);
        if (mag_ux[32] | mag_uz[32] | mag_wx[32] | mag_wz[32]) begin
            shift = 2'd3;
        end else if (mag_ux[31] | mag_uz[31] | mag_wx[31] | mag_wz[31]) begin
            shift = 2'd2;
        end else if (mag_ux[30] | mag_uz[30] | mag_wx[30] | mag_wz[30]) begin
            shift = 2'd1;
        end else begin
            shift = 2'd0;
        end
    end

    always_comb begin
        nmag = (step_reg >= K_NLO_Z) ? (nz_reg[63] ? 64'(-nz_reg) : nz_reg)
                                     : (nx_reg[63] ? 64'(-nx_reg) : nx_reg);
        case (step_reg)
            K_UXX:   begin opa = ux_reg; opb = ux_reg; end
            K_UZZ:   begin opa = uz_reg; opb = uz_reg; end
            K_WXX:   begin opa = wx_reg; opb = wx_reg; end
            K_WZZ:   begin opa = wz_reg; opb = wz_reg; end
            K_CA:    begin opa = {1'b0, c_reg}; opb = {1'b0, a_reg}; end
            K_UWX:   begin opa = ux_reg; opb = wx_reg; end
            K_UWZ:   begin opa = uz_reg; opb = wz_reg; end
            K_CUZ:   begin opa = {1'b0, c_reg}; opb = uz_reg; end
            K_AWZ:   begin opa = {1'b0, a_reg}; opb = wz_reg; end
            K_AWX:   begin opa = {1'b0, a_reg}; opb = wx_reg; end
            K_CUX:   begin opa = {1'b0, c_reg}; opb = ux_reg; end
            K_NLO_X, K_NLO_Z: begin
                opa = {4'b0, ow_reg, 12'b0};
                opb = {1'b0, nmag[30:0]};
            end
            K_NHI_X, K_NHI_Z: begin
                opa = {4'b0, ow_reg, 12'b0};
                opb = {1'b0, nmag[61:31]};
            end
            default: begin opa = '0; opb = '0; end
        endcase
    end

    assign acc_add = acc_reg + prod_reg;
    assign acc_sub = acc_reg - prod_reg;
    assign p_hi    = prod_reg[58:0] + {31'b0, p0_reg[58:31]};
    assign q_pos   = {1'b0, it_sts.value};

    always_comb begin
        it_ctl.start = 1'b0;
        it_ctl.op    = OP_SQRT;
        if (state_reg == ST_ACC) begin
            if ((step_reg == K_UZZ) || (step_reg == K_WZZ)) begin
                it_ctl.start = 1'b1;
            end else if ((step_reg == K_NHI_X) || (step_reg == K_NHI_Z)) begin
                it_ctl.start = 1'b1;
                it_ctl.op    = OP_DIV;
            end
        end
    end
    assign it_rad = acc_add[61:0];
    assign it_dvd = {p_hi, p0_reg[30:0]};

    pmo_iter u_iter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (it_ctl),
        .radicand (it_rad),
        .dividend (it_dvd),
        .divisor  (d_reg),
        .sts      (it_sts)
    );

    // output arithmetic with saturation
    always_comb begin
        mx44        = {{12{mid_x_reg[31]}}, mid_x_reg};
        mz44        = {{12{mid_z_reg[31]}}, mid_z_reg};
        wr44        = {16'b0, ow_reg, 12'b0};
        near_x_full = flat_reg ? (mx44 - wr44) : (mx44 + {{2{offx_reg[41]}}, offx_reg});
        near_z_full = mz44 + {{2{offz_reg[41]}}, offz_reg};
        near_x_sat  = sat32(near_x_full);
        near_z_sat  = sat32(near_z_full);
        far_x_full  = (mx44 <<< 1) - {{12{near_x_sat[31]}}, near_x_sat};
        far_z_full  = (mz44 <<< 1) - {{12{near_z_sat[31]}}, near_z_sat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ow_reg <= '0;
        end else if (cfg_wr_en) begin
            ow_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pts_reg     <= 2'd0;
            older_x_reg <= '0;
            older_z_reg <= '0;
            newer_x_reg <= '0;
            newer_z_reg <= '0;
            newer_h_reg <= '0;
            phase_reg   <= 1'b0;
            step_reg    <= K_UXX;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        if (pts_reg == 2'd0) begin
                            if (!s_last_point) begin
                                newer_x_reg <= s_point_x;
                                newer_z_reg <= s_point_z;
                                newer_h_reg <= s_point_height;
                                pts_reg     <= 2'd1;
                            end
                        end else begin
                            phase_reg <= 1'b0;
                            state_reg <= ST_DIFF;
                        end
                    end
                end
                ST_DIFF: begin
                    state_reg <= ST_SHRINK;
                end
                ST_SHRINK: begin
                    step_reg  <= K_UXX;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if ((step_reg == K_UZZ) || (step_reg == K_WZZ)) begin
                        state_reg <= ST_SQRT;
                    end else if ((step_reg == K_NHI_X) || (step_reg == K_NHI_Z)) begin
                        state_reg <= ST_DIV;
                    end else begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_SQRT: begin
                    if (it_sts.done) begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    if (it_sts.done) begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= (step_reg == K_NHI_X) ? ST_MUL : ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        if (!phase_reg && in_last_reg) begin
                            // tail window around the last vertex
                            phase_reg <= 1'b1;
                            state_reg <= ST_DIFF;
                        end else begin
                            state_reg <= ST_IDLE;
                            phase_reg <= 1'b0;
                            if (in_last_reg) begin
                                pts_reg     <= 2'd0;
                                older_x_reg <= '0;
                                older_z_reg <= '0;
                                newer_x_reg <= '0;
                                newer_z_reg <= '0;
                                newer_h_reg <= '0;
                            end else begin
                                pts_reg     <= 2'd2;
                                older_x_reg <= newer_x_reg;
                                older_z_reg <= newer_z_reg;
                                newer_x_reg <= in_x_reg;
                                newer_z_reg <= in_z_reg;
                                newer_h_reg <= in_h_reg;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_x_reg    <= s_point_x;
            in_z_reg    <= s_point_z;
            in_h_reg    <= s_point_height;
            in_last_reg <= s_last_point;
        end
        if (state_reg == ST_DIFF) begin
            mid_x_reg <= phase_reg ? in_x_reg : newer_x_reg;
            mid_z_reg <= phase_reg ? in_z_reg : newer_z_reg;
            hgt_reg   <= phase_reg ? in_h_reg : newer_h_reg;
            eol_reg   <= phase_reg;
            dux_reg   <= u_x;
            duz_reg   <= u_z;
            dwx_reg   <= w_x;
            dwz_reg   <= w_z;
        end
        if (state_reg == ST_SHRINK) begin
            ux_reg   <= shrink(dux_reg, shift);
            uz_reg   <= shrink(duz_reg, shift);
            wx_reg   <= shrink(dwx_reg, shift);
            wz_reg   <= shrink(dwz_reg, shift);
            sh_reg   <= shift;
            flat_reg <= (duz_reg == 33'sd0);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= opa * opb;
        end
        if (state_reg == ST_ACC) begin
            case (step_reg)
                K_UXX, K_WXX, K_CA, K_CUZ, K_AWX: begin
                    acc_reg <= prod_reg;
                end
                K_UWX: begin
                    acc_reg <= acc_sub;
                end
                K_UWZ: begin
                    // non-positive denominator falls back to the floor value
                    if (acc_sub[63] || (acc_sub == 64'sd0)) begin
                        d_reg <= 62'(DEN_FLOOR >> {sh_reg, 1'b0});
                    end else begin
                        d_reg <= acc_sub[61:0];
                    end
                end
                K_AWZ: begin
                    nx_reg <= acc_sub;
                end
                K_CUX: begin
                    nz_reg <= acc_sub;
                end
                K_NLO_X, K_NLO_Z: begin
                    p0_reg <= prod_reg[58:0];
                end
                default: begin
                end
            endcase
        end
        if ((state_reg == ST_SQRT) && it_sts.done) begin
            if (step_reg == K_UZZ) begin
                a_reg <= it_sts.value[30:0];
            end else begin
                c_reg <= it_sts.value[30:0];
            end
        end
        if ((state_reg == ST_DIV) && it_sts.done) begin
            if (step_reg == K_NHI_X) begin
                offx_reg <= nx_reg[63] ? -q_pos : q_pos;
            end else begin
                offz_reg <= nz_reg[63] ? -q_pos : q_pos;
            end
        end
        if ((state_reg == ST_OUT) && !m_valid_reg) begin
            near_x_reg  <= near_x_sat;
            near_z_reg  <= near_z_sat;
            far_x_reg   <= sat32(far_x_full);
            far_z_reg   <= sat32(far_z_full);
            height_reg  <= hgt_reg;
            eol_out_reg <= eol_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_near_x      = near_x_reg;
    assign m_near_z      = near_z_reg;
    assign m_far_x       = far_x_reg;
    assign m_far_z       = far_z_reg;
    assign m_out_height  = height_reg;
    assign m_end_of_line = eol_out_reg;

endmodule
`default_nettype wire

FILE: rtl/pmo_iter.sv
`default_nettype none
module pmo_iter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pmo_pkg::iter_ctl_t ctl,
    input  wire logic [61:0]       radicand,
    input  wire logic [89:0]       dividend,
    input  wire logic [61:0]       divisor,
    output pmo_pkg::iter_sts_t     sts
);
    import pmo_pkg::*;

    logic        op_reg;
    logic        run_reg;
    logic        done_reg;
    logic [6:0]  cnt_reg;
    logic [89:0] src_reg;
    logic [62:0] rem_reg;
    logic [40:0] res_reg;
    logic        ovf_reg;
    logic [61:0] den_reg;

    logic [62:0] sq_rem;
    logic [62:0] sq_trial;
    logic        sq_ge;
    logic [62:0] dv_rem;
    logic        dv_ge;

    // square root takes two radicand bits a step, division one dividend bit
    assign sq_rem   = {rem_reg[60:0], src_reg[89:88]};
    assign sq_trial = {30'b0, res_reg[30:0], 2'b01};
    assign sq_ge    = (sq_rem >= sq_trial);
    assign dv_rem   = {rem_reg[61:0], src_reg[89]};
    assign dv_ge    = (dv_rem >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end else if (ctl.start) begin
            op_reg   <= ctl.op;
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= (ctl.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            src_reg <= (ctl.op == OP_SQRT) ? {radicand, 28'b0} : dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            res_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (run_reg) begin
            if (op_reg == OP_SQRT) begin
                rem_reg <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
                res_reg <= {res_reg[39:0], sq_ge};
                src_reg <= src_reg << 2;
            end else begin
                rem_reg <= dv_ge ? (dv_rem - {1'b0, den_reg}) : dv_rem;
                ovf_reg <= ovf_reg | res_reg[40];
                res_reg <= {res_reg[39:0], dv_ge};
                src_reg <= src_reg << 1;
            end
        end
    end

    always_comb begin
        sts.done = done_reg;
        if (op_reg == OP_SQRT) begin
            sts.value = res_reg;
        end else if (ovf_reg || (res_reg > QUOT_CAP)) begin
            sts.value = QUOT_CAP;
        end else begin
            sts.value = res_reg;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/pmo_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pmo_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [31:0] m_near_x,
    input wire logic               m_end_of_line
);

    // a waiting result transaction holds
    `PMO_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_near_x))

    // results are far apart: none right after one is taken
    `PMO_ASSERT_NXT(a_out_gap, aclk, aresetn, m_valid && m_ready, !m_valid)

    // a result never appears in the cycle after an input transaction
    `PMO_ASSERT_NXT(a_no_quick_out, aclk, aresetn, s_valid && s_ready, !$rose(m_valid))

    // the input opens as soon as the tail result of a line is posted
    `PMO_ASSERT_IMP(a_eol_idle, aclk, aresetn, $rose(m_valid) && m_end_of_line, s_ready)

endmodule

bind polyline_miter_offset pmo_checker u_pmo_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_near_x      (m_near_x),
    .m_end_of_line (m_end_of_line)
);
`default_nettype wire
